### rtl/lsdrs_pkg.sv
`timescale 1ns / 1ps
package lsdrs_pkg;

    localparam int NREC   = 1024;
    localparam int AW     = $clog2(NREC);
    localparam int CW     = $clog2(NREC + 1);
    localparam int BASE   = 10;
    localparam int DW     = $clog2(BASE);
    localparam int KEY_W  = 31;
    localparam int TAG_W  = 16;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] load_key;
        logic [TAG_W-1:0] load_tag;
        logic             load_last;
    } t_req;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic [TAG_W-1:0] sorted_tag;
        logic             final_record;
        logic             read_valid;
    } t_rsp;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_LOAD_LAST,
        CMD_READ
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] quot;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_NEXT,
        ST_COUNT,
        ST_PREFIX,
        ST_SCATTER,
        ST_COPY
    } t_state;

    function automatic logic [KEY_W-1:0] div10(input logic [KEY_W-1:0] q);
        logic [63:0] p;
        p = {33'd0, q} * 64'h0000_0000_CCCC_CCCD;
        return KEY_W'(p >> 35);
    endfunction

    function automatic logic [DW-1:0] mod10(input logic [KEY_W-1:0] q);
        logic [KEY_W-1:0] d;
        d = div10(q);
        return DW'(q - ((d << 3) + (d << 1)));
    endfunction

endpackage

### rtl/lsdrs_ram.sv
`timescale 1ns / 1ps
module lsdrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/lsdrs_queue.sv
`timescale 1ns / 1ps
module lsdrs_queue import lsdrs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    output logic   o_full,
    input  logic   i_pop,
    output t_qhead o_head
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;

    assign o_full       = (r_cnt == QCW'(QDEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCW'(i_push) - QCW'(i_pop);
        end
    end

endmodule

### rtl/lsdrs_engine.sv
`timescale 1ns / 1ps
module lsdrs_engine import lsdrs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qhead i_head,
    output logic   o_pop,
    input  logic   i_out_stall,
    output logic   o_out_valid,
    output t_rsp   o_rsp
);

    t_state           r_st, n_st;
    logic [CW-1:0]    r_n, n_n;
    logic [CW-1:0]    r_rp, n_rp;
    logic             r_ready, n_ready;
    logic [KEY_W-1:0] r_large, n_large;
    logic [KEY_W-1:0] r_lq, n_lq;
    logic [CW-1:0]    r_cnt [BASE];
    logic [CW-1:0]    n_cnt [BASE];
    logic [CW-1:0]    r_iss, n_iss;
    logic [CW-1:0]    r_wi, n_wi;
    logic             r_v1, n_v1;
    logic             r_v2;
    logic [DW-1:0]    r_d2;
    t_rec             r_w2;
    logic             r_ov, n_ov;
    t_rsp             r_rsp, n_rsp;

    logic             we_a, we_b;
    logic [AW-1:0]    waddr_a, raddr_a, waddr_b, raddr_b;
    t_rec             wdata_a, wdata_b, rdata_a, rdata_b;

    logic             issuing;
    logic [CW-1:0]    eff_n;
    logic [CW-1:0]    pos;
    logic [CW-1:0]    sidx;
    logic [KEY_W-1:0] new_large;

    lsdrs_ram #(.WIDTH(REC_W), .DEPTH(NREC)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr_a),
        .i_wdata (wdata_a),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    lsdrs_ram #(.WIDTH(REC_W), .DEPTH(NREC)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr_b),
        .i_wdata (wdata_b),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    assign o_out_valid = r_ov;
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_n     <= '0;
            r_rp    <= '0;
            r_ready <= 1'b0;
            r_large <= '0;
            r_lq    <= '0;
            r_iss   <= '0;
            r_wi    <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_ov    <= 1'b0;
            for (int i = 0; i < BASE; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_st    <= n_st;
            r_n     <= n_n;
            r_rp    <= n_rp;
            r_ready <= n_ready;
            r_large <= n_large;
            r_lq    <= n_lq;
            r_iss   <= n_iss;
            r_wi    <= n_wi;
            r_v1    <= n_v1;
            r_v2    <= r_v1;
            r_ov    <= n_ov;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp     <= n_rsp;
        r_d2      <= mod10(rdata_a.quot);
        r_w2.key  <= rdata_a.key;
        r_w2.tag  <= rdata_a.tag;
        r_w2.quot <= div10(rdata_a.quot);
    end

    always_comb begin
        n_st      = r_st;
        n_n       = r_n;
        n_rp      = r_rp;
        n_ready   = r_ready;
        n_large   = r_large;
        n_lq      = r_lq;
        n_cnt     = r_cnt;
        n_iss     = r_iss;
        n_wi      = r_wi;
        n_v1      = 1'b0;
        n_ov      = r_ov && i_out_stall;
        n_rsp     = r_rsp;
        o_pop     = 1'b0;
        we_a      = 1'b0;
        waddr_a   = r_n[AW-1:0];
        wdata_a   = '0;
        raddr_a   = r_iss[AW-1:0];
        we_b      = 1'b0;
        waddr_b   = '0;
        wdata_b   = r_w2;
        raddr_b   = r_iss[AW-1:0];
        issuing   = (r_iss != r_n);
        eff_n     = r_ready ? '0 : r_n;
        pos       = r_cnt[r_d2] - 1'b1;
        sidx      = r_n - r_iss - 1'b1;
        new_large = r_large;

        unique case (r_st)
            ST_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.cmd.kind == CMD_READ) begin
                        if (!r_ov || !i_out_stall) begin
                            o_pop = 1'b1;
                            if (!r_ready || (r_rp >= r_n)) begin
                                n_ready = 1'b0;
                                n_ov    = 1'b1;
                                n_rsp   = '0;
                            end else begin
                                raddr_a = r_rp[AW-1:0];
                                n_st    = ST_RD_WAIT;
                            end
                        end
                    end else begin
                        o_pop = 1'b1;
                        if (r_ready) begin
                            n_ready = 1'b0;
                            n_rp    = '0;
                        end
                        n_n = eff_n;
                        if (eff_n < CW'(NREC)) begin
                            we_a         = 1'b1;
                            waddr_a      = eff_n[AW-1:0];
                            wdata_a.key  = i_head.cmd.key;
                            wdata_a.tag  = i_head.cmd.tag;
                            wdata_a.quot = i_head.cmd.key;
                            n_n          = eff_n + 1'b1;
                            if ((eff_n == '0) || (i_head.cmd.key > r_large)) begin
                                new_large = i_head.cmd.key;
                            end
                            n_large = new_large;
                        end
                        if (i_head.cmd.kind == CMD_LOAD_LAST) begin
                            n_lq = new_large;
                            n_st = ST_NEXT;
                        end
                    end
                end
            end
            ST_RD_WAIT: begin
                n_ov             = 1'b1;
                n_rsp.sorted_key = rdata_a.key;
                n_rsp.sorted_tag = rdata_a.tag;
                n_rsp.read_valid = 1'b1;
                if ((r_rp + 1'b1) >= r_n) begin
                    n_rsp.final_record = 1'b1;
                    n_ready            = 1'b0;
                    n_n                = '0;
                    n_rp               = '0;
                end else begin
                    n_rsp.final_record = 1'b0;
                    n_rp               = r_rp + 1'b1;
                end
                n_st = ST_IDLE;
            end
            ST_NEXT: begin
                if (r_lq == '0) begin
                    n_ready = (r_n != '0);
                    n_rp    = '0;
                    n_st    = ST_IDLE;
                end else begin
                    for (int i = 0; i < BASE; i++) begin
                        n_cnt[i] = '0;
                    end
                    n_iss = '0;
                    n_st  = ST_COUNT;
                end
            end
            ST_COUNT: begin
                if (issuing) begin
                    n_v1  = 1'b1;
                    n_iss = r_iss + 1'b1;
                end
                if (r_v2) begin
                    n_cnt[r_d2] = r_cnt[r_d2] + 1'b1;
                end
                if (!issuing && !r_v1 && !r_v2) begin
                    n_st = ST_PREFIX;
                end
            end
            ST_PREFIX: begin
                for (int i = 1; i < BASE; i++) begin
                    n_cnt[i] = r_cnt[i] + n_cnt[i-1];
                end
                n_iss = '0;
                n_st  = ST_SCATTER;
            end
            ST_SCATTER: begin
                raddr_a = sidx[AW-1:0];
                if (issuing) begin
                    n_v1  = 1'b1;
                    n_iss = r_iss + 1'b1;
                end
                if (r_v2) begin
                    n_cnt[r_d2] = pos;
                    we_b        = 1'b1;
                    waddr_b     = pos[AW-1:0];
                end
                if (!issuing && !r_v1 && !r_v2) begin
                    n_iss = '0;
                    n_wi  = '0;
                    n_st  = ST_COPY;
                end
            end
            ST_COPY: begin
                if (issuing) begin
                    n_v1  = 1'b1;
                    n_iss = r_iss + 1'b1;
                end
                if (r_v1) begin
                    we_a    = 1'b1;
                    waddr_a = r_wi[AW-1:0];
                    wdata_a = rdata_b;
                    n_wi    = r_wi + 1'b1;
                end
                if (!issuing && !r_v1 && !r_v2) begin
                    n_lq = div10(r_lq);
                    n_st = ST_NEXT;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(NREC))
        else $error("Record count exceeds capacity.");

    a_ready_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_n != '0))
        else $error("Sorted set marked ready with no records.");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_COUNT || r_st == ST_SCATTER || r_st == ST_COPY) |-> (r_iss <= r_n))
        else $error("Pass issued more reads than records held.");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_st == ST_IDLE))
        else $error("Command taken while a sort is running.");

endmodule

### rtl/lsd_decimal_radix_sorter_unit.sv
`timescale 1ns / 1ps
// A load is written in the engine's idle state; a read waits in a read state for the record memory port.
// After the last load the sort runs one pass per decimal digit of the largest key.
// In each pass the count, scatter and copy steps each read every record once: count and scatter
// through the read port of record memory A, copy through that of memory B; no commands are taken meanwhile.
// Reset is synchronous and active low; it empties the queue and discards any loaded set.
module lsd_decimal_radix_sorter_unit import lsdrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    t_cmd   cmd;
    t_qhead head;
    logic   full;
    logic   pop;

    always_comb begin
        cmd.key = i_req.load_key;
        cmd.tag = i_req.load_tag;
        if (i_req.req_type) begin
            cmd.kind = CMD_READ;
        end else if (i_req.load_last) begin
            cmd.kind = CMD_LOAD_LAST;
        end else begin
            cmd.kind = CMD_LOAD;
        end
    end

    assign o_stall = full;

    lsdrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !full),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head)
    );

    lsdrs_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_rsp       (o_rsp)
    );

endmodule
